[src/assert_macros.svh]
// assertion macros shared by the sorted key/quantity table rtl
// no dependencies; clocked on clk; SKQT_ASSERT is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define SKQT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising clk edge, reset included
`define SKQT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/skqt_pkg.sv]
// types and codes of the sorted key/quantity table
// used by skqt_cell and sorted_key_quantity_table; no dependencies
package skqt_pkg;

  localparam int KEY_W = 32;
  localparam int QTY_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  typedef struct packed {
    action_t                   action;
    logic signed [KEY_W-1:0]   key;
    logic signed [QTY_W-1:0]   qty;
  } cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]   key;
    logic signed [QTY_W-1:0]   qty;
  } entry_t;

  // per-cell compare results handed to the next cell up the chain
  typedef struct packed {
    logic le;
    logic eq;
  } cell_flags_t;

  // broadcast controls for one cycle of the chain
  typedef struct packed {
    logic ins;
    logic upd;
    logic rot;
  } cell_ctl_t;

endpackage

[src/skqt_cell.sv]
// one cell of the sorted chain: holds one entry, compares it to the command key,
// shifts up on insert, rewrites the quantity on update and rotates down on dump; depends on skqt_pkg
module skqt_cell (
  input  logic                 clk,
  input  logic                 valid,
  input  skqt_pkg::cmd_t       cmd,
  input  skqt_pkg::cell_ctl_t  ctl,
  input  skqt_pkg::cell_flags_t prev_flags,
  input  skqt_pkg::entry_t     prev_entry,
  input  skqt_pkg::entry_t     next_entry,
  output skqt_pkg::cell_flags_t flags,
  output logic                 first,
  output skqt_pkg::entry_t     entry,
  output logic signed [31:0]   hit_qty
);
  import skqt_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    flags.le = valid && (entry_r.key <= cmd.key);
    flags.eq = valid && (entry_r.key == cmd.key);
    first    = flags.eq && !prev_flags.eq;
    hit_qty  = first ? entry_r.qty : '0;
    entry    = entry_r;

    entry_nxt = entry_r;
    if (ctl.rot) begin
      entry_nxt = next_entry;
    end else if (ctl.ins && !flags.le) begin
      // insert point is the lowest cell that is empty or whose key is greater
      if (prev_flags.le) begin
        entry_nxt.key = cmd.key;
        entry_nxt.qty = cmd.qty;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctl.upd && first) begin
      entry_nxt.qty = cmd.qty;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[src/sorted_key_quantity_table.sv]
// top level of the sorted key/quantity table: command register, sequencer,
// chain of skqt_cell and result register; depends on skqt_pkg, skqt_cell
//
//  channel  ports                                     handshake
//  in       in_action in_part_number in_quantity      start, taken when busy low
//  out      out_status out_entry_key out_entry_quantity out_last  out_valid strobe
//
// insert, search and update: S_IDLE captures the word, then in S_EXEC every cell
// compares with the key and shifts or writes in parallel; the result word
// leaves from a register the cycle after, while the next word may already be
// taken. dump on a non-empty table runs S_DUMP after S_EXEC, the chain rotating
// once through all cells and giving one result word per stored entry. reset
// empties the table; results cannot be stalled.
`include "assert_macros.svh"

module sorted_key_quantity_table #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  skqt_pkg::action_t    in_action,
  input  logic signed [31:0]   in_part_number,
  input  logic signed [31:0]   in_quantity,
  output logic                 out_valid,
  output skqt_pkg::status_t    out_status,
  output logic signed [31:0]   out_entry_key,
  output logic signed [31:0]   out_entry_quantity,
  output logic                 out_last
);
  import skqt_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic signed [31:0] out_key_r, out_key_nxt;
  logic signed [31:0] out_qty_r, out_qty_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctl_t         ctl;
  cell_flags_t       flags   [DEPTH];
  entry_t            entries [DEPTH];
  logic signed [31:0] hit_q  [DEPTH];
  logic [DEPTH-1:0]  first_v;
  logic              hit_any;
  logic signed [31:0] hit_qty;
  logic              full, empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      cell_flags_t prev_f;
      entry_t      prev_e;
      entry_t      next_e;
      logic        cvalid;

      assign cvalid = CNT_W'(g) < count_r;

      if (g == 0) begin : g_bottom
        assign prev_f = '{le: 1'b1, eq: 1'b0};
        assign prev_e = entries[0];
      end else begin : g_upper
        assign prev_f = flags[g-1];
        assign prev_e = entries[g-1];
      end

      assign next_e = entries[(g + 1) % DEPTH];

      skqt_cell u_cell (
        .clk        (clk),
        .valid      (cvalid),
        .cmd        (cmd_r),
        .ctl        (ctl),
        .prev_flags (prev_f),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .flags      (flags[g]),
        .first      (first_v[g]),
        .entry      (entries[g]),
        .hit_qty    (hit_q[g])
      );
    end
  endgenerate

  always_comb begin
    hit_qty = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_qty = hit_qty | hit_q[i];
    end
  end

  assign hit_any = |first_v;
  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ctl            = '0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_key_nxt    = '0;
    out_qty_nxt    = '0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt.action = in_action;
          cmd_nxt.key    = in_part_number;
          cmd_nxt.qty    = in_quantity;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (cmd_r.action)
          ACT_INSERT: begin
            if (full) begin
              out_status_nxt = STAT_FULL;
            end else begin
              ctl.ins     = 1'b1;
              count_nxt   = count_r + CNT_W'(1);
              out_key_nxt = cmd_r.key;
              out_qty_nxt = cmd_r.qty;
            end
          end
          ACT_SEARCH, ACT_UPDATE: begin
            if (empty) begin
              out_status_nxt = STAT_EMPTY;
            end else if (!hit_any) begin
              out_status_nxt = STAT_NOTFOUND;
            end else begin
              ctl.upd     = cmd_r.action == ACT_UPDATE;
              out_key_nxt = cmd_r.key;
              out_qty_nxt = (cmd_r.action == ACT_UPDATE) ? cmd_r.qty : hit_qty;
            end
          end
          ACT_DUMP: begin
            if (empty) begin
              out_status_nxt = STAT_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              idx_nxt       = '0;
              state_nxt     = S_DUMP;
            end
          end
          default: begin
            out_status_nxt = STAT_EMPTY;
          end
        endcase
      end
      S_DUMP: begin
        ctl.rot       = 1'b1;
        out_valid_nxt = CNT_W'(idx_r) < count_r;
        out_key_nxt   = entries[0].key;
        out_qty_nxt   = entries[0].qty;
        out_last_nxt  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
        idx_nxt       = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_qty_r    <= out_qty_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_key      = out_key_r;
  assign out_entry_quantity = out_qty_r;
  assign out_last           = out_last_r;

  `SKQT_ASSERT(a_count_range, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `SKQT_ASSERT(a_count_by_insert, (count_r != $past(count_r)) |-> $past(ctl.ins), "count moved without insert")
  `SKQT_ASSERT(a_full_report, (out_valid && (out_status == STAT_FULL)) |-> full, "full reported on table with room")
  `SKQT_ASSERT(a_dump_burst, (out_valid && !out_last) |=> out_valid, "dump words not back to back")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench for sorted_key_quantity_table: directed and random commands against
// a shadow copy of the sorted table; depends on skqt_pkg and the rtl in src

module testbench;
  import skqt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    status_t            status;
    logic signed [31:0] key;
    logic signed [31:0] qty;
    logic               last;
  } reply_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  action_t            in_action;
  logic signed [31:0] in_part_number;
  logic signed [31:0] in_quantity;
  logic               out_valid;
  status_t            out_status;
  logic signed [31:0] out_entry_key;
  logic signed [31:0] out_entry_quantity;
  logic               out_last;

  logic signed [31:0] shadow_keys [TABLE_DEPTH];
  logic signed [31:0] shadow_qtys [TABLE_DEPTH];
  int                 shadow_count;
  reply_t             expected_replies [$];
  reply_t             head_reply;
  int                 mismatch_count;
  int                 sender_idle_pct;

  sorted_key_quantity_table #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_part_number    (in_part_number),
    .in_quantity       (in_quantity),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entry_key     (out_entry_key),
    .out_entry_quantity(out_entry_quantity),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(string field, logic signed [31:0] got,
                                 logic signed [31:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
  endtask

  function automatic void add_reply(status_t status, logic signed [31:0] key,
                                    logic signed [31:0] qty, logic last);
    reply_t r;
    r.status = status;
    r.key    = key;
    r.qty    = qty;
    r.last   = last;
    expected_replies.push_back(r);
  endfunction

  // shadow table update and expected result words for one accepted command
  function automatic void predict_replies(action_t act, logic signed [31:0] key,
                                          logic signed [31:0] qty);
    int pos;
    int i;
    pos = 0;
    if (act == ACT_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        add_reply(STAT_FULL, '0, '0, 1'b1);
      end else begin
        while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_qtys[i] = shadow_qtys[i-1];
        end
        shadow_keys[pos] = key;
        shadow_qtys[pos] = qty;
        shadow_count++;
        add_reply(STAT_OK, key, qty, 1'b1);
      end
    end else if (shadow_count == 0) begin
      add_reply(STAT_EMPTY, '0, '0, 1'b1);
    end else if (act == ACT_DUMP) begin
      for (i = 0; i < shadow_count; i++)
        add_reply(STAT_OK, shadow_keys[i], shadow_qtys[i], i == shadow_count - 1);
    end else begin
      while (pos < shadow_count && shadow_keys[pos] != key) pos++;
      if (pos == shadow_count) begin
        add_reply(STAT_NOTFOUND, '0, '0, 1'b1);
      end else begin
        if (act == ACT_UPDATE) shadow_qtys[pos] = qty;
        add_reply(STAT_OK, shadow_keys[pos], shadow_qtys[pos], 1'b1);
      end
    end
  endfunction

  task automatic send_command(action_t act, logic signed [31:0] key,
                              logic signed [31:0] qty);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, TABLE_DEPTH + 4)
                                        : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    start          = 1'b1;
    in_action      = act;
    in_part_number = key;
    in_quantity    = qty;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_replies(act, key, qty);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected word, key", out_entry_key, '0);
      end else begin
        head_reply = expected_replies.pop_front();
        if (out_status != head_reply.status)
          report_mismatch("status", 32'(out_status), 32'(head_reply.status));
        if (out_entry_key !== head_reply.key)
          report_mismatch("entry_key", out_entry_key, head_reply.key);
        if (out_entry_quantity !== head_reply.qty)
          report_mismatch("entry_quantity", out_entry_quantity, head_reply.qty);
        if (out_last !== head_reply.last)
          report_mismatch("last", 32'(out_last), 32'(head_reply.last));
      end
    end
  end

  task automatic test_empty_table();
    send_command(ACT_SEARCH, '0, '0);
    send_command(ACT_UPDATE, KEY_MAX, KEY_MIN);
    send_command(ACT_DUMP, KEY_MIN, KEY_MAX);
    send_command(ACT_SEARCH, KEY_MIN, '1);
  endtask

  task automatic test_ordering_and_duplicates();
    send_command(ACT_INSERT, KEY_MAX, KEY_MIN);
    send_command(ACT_INSERT, KEY_MIN, KEY_MAX);
    send_command(ACT_INSERT, '0, '0);
    send_command(ACT_INSERT, -32'sd1, -32'sd1);
    send_command(ACT_INSERT, 32'sd7, 32'sd1);
    send_command(ACT_INSERT, 32'sd7, 32'sd2);
    send_command(ACT_INSERT, 32'sd7, 32'sd3);
    send_command(ACT_INSERT, -32'sd1, 32'sd55);
    send_command(ACT_SEARCH, 32'sd7, '0);
    send_command(ACT_UPDATE, 32'sd7, 32'sd99);
    send_command(ACT_SEARCH, 32'sd7, '1);
    send_command(ACT_SEARCH, 32'sd8, '0);
    send_command(ACT_UPDATE, 32'sd8, 32'sd5);
    send_command(ACT_SEARCH, KEY_MIN, '0);
    send_command(ACT_UPDATE, KEY_MAX, KEY_MAX);
    send_command(ACT_DUMP, '1, '1);
  endtask

  // mostly hits on stored keys, inserts fill the table gradually up to full
  task automatic test_random_mix(int idle_pct, int n_words);
    int                 pick;
    action_t            act;
    logic signed [31:0] key;
    logic signed [31:0] qty;
    sender_idle_pct = idle_pct;
    repeat (n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) act = ACT_INSERT;
      else if (pick < 50) act = ACT_SEARCH;
      else if (pick < 82) act = ACT_UPDATE;
      else act = ACT_DUMP;
      pick = $urandom_range(0, 99);
      if (shadow_count > 0 && pick < ((act == ACT_INSERT) ? 30 : 70))
        key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else if (pick < 85)
        key = $urandom;
      else case ($urandom_range(0, 3))
        0: key = KEY_MIN;
        1: key = KEY_MAX;
        2: key = '0;
        default: key = '1;
      endcase
      qty = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX)
                                         : $urandom;
      send_command(act, key, qty);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_INSERT;
    in_part_number  = '0;
    in_quantity     = '0;
    shadow_count    = 0;
    mismatch_count  = 0;
    sender_idle_pct = 31;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_ordering_and_duplicates();
    test_random_mix(31, 64);
    test_random_mix(79, 64);
    test_random_mix(0, 64);

    @(negedge clk);
    start = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sorted_key_quantity_table.f]
+incdir+src
src/skqt_pkg.sv
src/skqt_cell.sv
src/sorted_key_quantity_table.sv
tb/testbench.sv
